// ----- rtl/i2c_master_byte_engine_top_defines.svh -----
// ----------------------------------------------------------------------------
// I2C master byte engine: assertion macros
// Shared assertion wrappers. Both expect clk and rst_n in scope, and both are
// empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
`define IBE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2c byte engine assertion failed");
`define IBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c byte engine assertion failed");
`else
`define IBE_ASSERT(lbl, prop)
`define IBE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command and status codes, field widths and the result item type.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int KindW    = 3;
  localparam int StatusW  = 2;
  localparam int TimeoutW = 15;
  localparam int TicksW   = 8;
  localparam int ByteW    = 8;
  localparam int BitIdxW  = 3;

  localparam logic [KindW-1:0] KIND_TICK  = 3'd0;
  localparam logic [KindW-1:0] KIND_START = 3'd1;
  localparam logic [KindW-1:0] KIND_STOP  = 3'd2;
  localparam logic [KindW-1:0] KIND_WRITE = 3'd3;
  localparam logic [KindW-1:0] KIND_READ  = 3'd4;
  localparam logic [KindW-1:0] KIND_WACK  = 3'd5;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_TIMEOUT = 2'd1;
  localparam logic [StatusW-1:0] ST_NACK    = 2'd2;
  localparam logic [StatusW-1:0] ST_REJECT  = 2'd3;

  localparam logic [TicksW-1:0]  TICKS_RESET = 8'd2;
  localparam logic [BitIdxW-1:0] TOP_BIT     = 3'd7;

  typedef struct packed {
    logic               scl;
    logic               sda;
    logic               busy;
    logic               done;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   rx_byte;
  } res_t;

endpackage

// ----- rtl/i2c_master_byte_engine_top.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine
// Sequencer for start, stop, byte write, byte read and wait-for-ACK on
// open-drain SCL and SDA, paced by tick items.
// ----------------------------------------------------------------------------
// Usage: every input item is a command (start, stop, write, read, wait ACK)
// or a tick that carries the sampled SDA level. Each accepted item yields
// exactly one result item with the line drives, busy, done, status and the
// last received byte. cfg_we/cfg_wdata set the number of ticks per half bit
// period; write it only while the engine is idle.
// The sequencer state is updated in the cycle an item is accepted and the
// result is registered. One item is taken every cycle while in_stall is
// low; the rate is set by the single state update that sits between the
// input handshake and the result register.
// Results pass through an output register backed by a one-entry skid
// register, so the input keeps flowing while a single result waits. in_stall
// rises only when both are full, and drops once the receiver takes a result.
// Reset (synchronous, rst_n low) returns the engine to idle with both lines
// released, the received byte cleared and phase_ticks set to 2.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_top_defines.svh"

module i2c_master_byte_engine_top
  import i2cmbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [TicksW-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KindW-1:0]    in_kind,
  input  logic [ByteW-1:0]    in_tx_byte,
  input  logic                in_send_ack,
  input  logic [TimeoutW-1:0] in_ack_timeout,
  input  logic                in_sda_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_scl_out,
  output logic                out_sda_out,
  output logic                out_busy_res,
  output logic                out_done_res,
  output logic [StatusW-1:0]  out_status,
  output logic [ByteW-1:0]    out_rx_byte
);

  localparam int PhW = 4;
  localparam logic [PhW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhW-1:0] PH_ST_A    = 4'd1;
  localparam logic [PhW-1:0] PH_ST_B    = 4'd2;
  localparam logic [PhW-1:0] PH_SP_A    = 4'd3;
  localparam logic [PhW-1:0] PH_WR_LOW  = 4'd4;
  localparam logic [PhW-1:0] PH_WR_HIGH = 4'd5;
  localparam logic [PhW-1:0] PH_WA_POLL = 4'd6;
  localparam logic [PhW-1:0] PH_WA_HIGH = 4'd7;
  localparam logic [PhW-1:0] PH_WA_LOW  = 4'd8;
  localparam logic [PhW-1:0] PH_RD_LOW  = 4'd9;
  localparam logic [PhW-1:0] PH_RD_HIGH = 4'd10;
  localparam logic [PhW-1:0] PH_RD_GAP  = 4'd11;
  localparam logic [PhW-1:0] PH_RD_ACKH = 4'd12;
  localparam logic [PhW-1:0] PH_RD_END  = 4'd13;

  logic [TicksW-1:0]   phase_ticks_r;
  logic [PhW-1:0]      phase_r, phase_nxt;
  logic [BitIdxW-1:0]  bit_idx_r, bit_idx_nxt;
  logic [ByteW-1:0]    shift_r, shift_nxt;
  logic [TicksW-1:0]   delay_r, delay_nxt;
  logic [TimeoutW-1:0] poll_r, poll_nxt;
  logic                scl_r, scl_nxt;
  logic                sda_r, sda_nxt;
  logic                ack_r, ack_nxt;
  logic [ByteW-1:0]    rx_r, rx_nxt;

  logic                out_valid_r, skid_valid_r;
  res_t                out_res_r, skid_res_r;
  res_t                res;

  logic                accept, take, busy, step;
  logic [TicksW-1:0]   load_val;
  logic [BitIdxW-1:0]  bit_dec;
  logic                done;
  logic [StatusW-1:0]  status;

  assign accept   = in_valid && !in_stall;
  assign take     = out_valid_r && !out_stall;
  assign busy     = (phase_r != PH_IDLE);
  assign load_val = (phase_ticks_r == '0) ? TicksW'(1) : phase_ticks_r;
  assign bit_dec  = bit_idx_r - BitIdxW'(1);
  // A step ends on the tick that takes the delay counter from one to zero.
  assign step     = (in_kind == KIND_TICK) && busy && (delay_r == TicksW'(1));

  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    delay_nxt   = delay_r;
    poll_nxt    = poll_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    rx_nxt      = rx_r;
    done        = 1'b0;
    status      = ST_OK;

    if (in_kind == KIND_TICK) begin
      if (busy) begin
        delay_nxt = delay_r - TicksW'(1);
      end
      if (step) begin
        case (phase_r)
          PH_ST_A: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_ST_B;
            delay_nxt = load_val;
          end
          PH_ST_B: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
          PH_SP_A: begin
            sda_nxt = 1'b1;
            done    = 1'b1;
          end
          PH_WR_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_WR_HIGH;
            delay_nxt = load_val;
          end
          PH_WR_HIGH: begin
            scl_nxt = 1'b0;
            if (bit_idx_r == '0) begin
              sda_nxt = 1'b1;
              done    = 1'b1;
            end else begin
              bit_idx_nxt = bit_dec;
              sda_nxt     = shift_r[bit_dec];
              phase_nxt   = PH_WR_LOW;
              delay_nxt   = load_val;
            end
          end
          PH_WA_POLL: begin
            if (poll_r == '0) begin
              done   = 1'b1;
              status = ST_TIMEOUT;
            end else if (in_sda_in) begin
              poll_nxt  = poll_r - TimeoutW'(1);
              delay_nxt = load_val;
            end else begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_WA_HIGH;
              delay_nxt = load_val;
            end
          end
          PH_WA_HIGH: begin
            if (in_sda_in) begin
              done   = 1'b1;
              status = ST_NACK;
            end else begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_WA_LOW;
              delay_nxt = load_val;
            end
          end
          PH_WA_LOW: begin
            done = 1'b1;
          end
          PH_RD_LOW: begin
            scl_nxt              = 1'b1;
            shift_nxt[bit_idx_r] = shift_r[bit_idx_r] | in_sda_in;
            phase_nxt            = PH_RD_HIGH;
            delay_nxt            = load_val;
          end
          PH_RD_HIGH: begin
            scl_nxt   = 1'b0;
            delay_nxt = load_val;
            if (bit_idx_r == '0) begin
              phase_nxt = PH_RD_GAP;
            end else begin
              bit_idx_nxt = bit_dec;
              phase_nxt   = PH_RD_LOW;
            end
          end
          PH_RD_GAP: begin
            sda_nxt   = !ack_r;
            scl_nxt   = 1'b1;
            phase_nxt = PH_RD_ACKH;
            delay_nxt = load_val;
          end
          PH_RD_ACKH: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            phase_nxt = PH_RD_END;
            delay_nxt = load_val;
          end
          PH_RD_END: begin
            rx_nxt = shift_r;
            done   = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          phase_nxt = PH_IDLE;
        end
      end
    end else if (in_kind inside {[KIND_START:KIND_WACK]}) begin
      if (busy) begin
        done   = 1'b1;
        status = ST_REJECT;
      end else begin
        delay_nxt = load_val;
        case (in_kind)
          KIND_START: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_ST_A;
          end
          KIND_STOP: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            phase_nxt = PH_SP_A;
          end
          KIND_WRITE: begin
            shift_nxt   = in_tx_byte;
            bit_idx_nxt = TOP_BIT;
            scl_nxt     = 1'b0;
            sda_nxt     = in_tx_byte[TOP_BIT];
            phase_nxt   = PH_WR_LOW;
          end
          KIND_READ: begin
            shift_nxt   = '0;
            bit_idx_nxt = TOP_BIT;
            ack_nxt     = in_send_ack;
            scl_nxt     = 1'b0;
            phase_nxt   = PH_RD_LOW;
          end
          default: begin
            poll_nxt  = in_ack_timeout;
            phase_nxt = PH_WA_POLL;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl     = scl_nxt;
    res.sda     = sda_nxt;
    res.busy    = (phase_nxt != PH_IDLE);
    res.done    = done;
    res.status  = status;
    res.rx_byte = rx_nxt;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= TICKS_RESET;
      phase_r       <= PH_IDLE;
      bit_idx_r     <= '0;
      shift_r       <= '0;
      delay_r       <= '0;
      poll_r        <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_r         <= 1'b0;
      rx_r          <= '0;
    end else begin
      if (cfg_we) begin
        phase_ticks_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r   <= phase_nxt;
        bit_idx_r <= bit_idx_nxt;
        shift_r   <= shift_nxt;
        delay_r   <= delay_nxt;
        poll_r    <= poll_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        ack_r     <= ack_nxt;
        rx_r      <= rx_nxt;
      end
    end
  end

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_res_r <= skid_res_r;
      end
    end else if (accept) begin
      if (out_valid_r && !take) begin
        skid_res_r <= res;
      end else begin
        out_res_r <= res;
      end
    end
  end

  assign in_stall     = skid_valid_r;
  assign out_valid    = out_valid_r;
  assign out_scl_out  = out_res_r.scl;
  assign out_sda_out  = out_res_r.sda;
  assign out_busy_res = out_res_r.busy;
  assign out_done_res = out_res_r.done;
  assign out_status   = out_res_r.status;
  assign out_rx_byte  = out_res_r.rx_byte;

  `IBE_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r)
  `IBE_ASSERT(a_delay_live, (phase_r == PH_IDLE) || (delay_r != '0))
  `IBE_ASSERT(a_reject_busy,
    !(out_valid_r && out_res_r.done && (out_res_r.status == ST_REJECT)) || out_res_r.busy)
  `IBE_ASSERT_NEXT(a_skid_drain, skid_valid_r && !out_stall, out_valid_r && !skid_valid_r)

endmodule
